>>> src/pool_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool_pkg: shared types and constants for the 2x2 pooling stream
// Sizes of the sample path, line store and counter chain, config register
// codes and the status word passed along the counter cells.
// ----------------------------------------------------------------------------
package pool_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int SAMPLE_BITS  = 16;
  localparam int PAIR_BITS    = SAMPLE_BITS + 1;
  localparam int OUT_BITS     = SAMPLE_BITS + 2;
  localparam int STORE_DEPTH  = MAX_WIDTH / 2;
  localparam int ADDR_BITS    = $clog2(STORE_DEPTH);
  localparam int DIM_BITS     = 11;
  localparam int PLANE_BITS   = 16;
  localparam int CNT_BITS     = 16;
  localparam int CFG_BITS     = 16;
  localparam int WIDTH_LIMIT  = MAX_WIDTH - (MAX_WIDTH % 2);
  localparam int HEIGHT_LIMIT = 1024;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_PLANE_COUNT  = 2'd2,
    REG_AVERAGE_MODE = 2'd3
  } cfg_reg_t;

  // status handed from one counter cell to the next
  typedef struct packed {
    logic at_end;  // count is on its last value
    logic carry;   // count wraps on this step
  } cnt_stat_t;

endpackage

>>> src/pool_cnt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool_cnt_cell: one wrapping counter cell of the position chain
// Advances on step, wraps to zero at its limit and hands the wrap on as
// the step of the next cell.
// ----------------------------------------------------------------------------
module pool_cnt_cell
  import pool_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [CNT_BITS-1:0] limit,
  output logic [CNT_BITS-1:0] count,
  output cnt_stat_t           stat
);

  logic [CNT_BITS:0] count_inc;

  assign count_inc   = {1'b0, count} + {{CNT_BITS{1'b0}}, 1'b1};
  // >= also wraps a count left past a lowered limit
  assign stat.at_end = count_inc >= {1'b0, limit};
  assign stat.carry  = step & stat.at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (step) begin
      if (stat.at_end) begin
        count <= '0;
      end else begin
        count <= count_inc[CNT_BITS-1:0];
      end
    end
  end

endmodule

>>> src/pool_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool_line_store: line store of upper-row pair sums
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pool_line_store
  import pool_pkg::*;
(
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [PAIR_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [PAIR_BITS-1:0] rd_data
);

  logic [PAIR_BITS-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/pool_2x2_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool_2x2_stream: streaming 2x2 stride-2 sum / average pooling
// Raster-order samples in, one pooled word per 2x2 window out, with plane
// and job end flags.
// ----------------------------------------------------------------------------
// Takes one sample word per clock, plane after plane in raster order, and
// emits one word per 2x2 window when its bottom-right sample is taken. The
// input side has no pipeline bubble: the only thing that holds a sample
// back is a full output register whose word is being stalled, so the
// sustained rate is one sample per cycle and a window result is registered in
// the cycle after its last sample. Position is tracked by a chain of three
// counter cells (column, row, plane), each passing its wrap to the next.
// Upper-row pair sums sit in a 512-entry line store; the entry for a window
// is read when the left sample of its lower pair arrives, so the registered
// read data is ready for the right sample. The store is not cleared after
// reset: every entry is written in an even row before an odd row reads it.
// Dimensions are clamped at write time (odd rounds down, minimum two,
// maximum 1024; zero planes count as one). Write config only while idle.
// ----------------------------------------------------------------------------
module pool_2x2_stream
  import pool_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  // config write port
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [CFG_BITS-1:0]           cfg_data,
  // sample stream
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  // result stream
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [OUT_BITS-1:0]    pooled_value,
  output logic                          last_of_plane,
  output logic                          last_of_job
);

  // round down to even, then clamp into [2, lim]
  function automatic logic [DIM_BITS-1:0] even_dim(input logic [DIM_BITS-1:0] v,
                                                   input logic [DIM_BITS-1:0] lim);
    logic [DIM_BITS-1:0] e;
    e = {v[DIM_BITS-1:1], 1'b0};
    if (e < DIM_BITS'(2)) begin
      e = DIM_BITS'(2);
    end
    if (e > lim) begin
      e = lim;
    end
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Config registers, held in their clamped form
  // ---------------------------------------------------------------------------
  logic [DIM_BITS-1:0]   width_lim;
  logic [DIM_BITS-1:0]   height_lim;
  logic [PLANE_BITS-1:0] plane_lim;
  logic                  avg_mode;
  cfg_reg_t              cfg_sel;

  assign cfg_sel = cfg_reg_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_lim  <= DIM_BITS'(2);
      height_lim <= DIM_BITS'(2);
      plane_lim  <= PLANE_BITS'(1);
      avg_mode   <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_IMAGE_WIDTH: begin
          width_lim <= even_dim(cfg_data[DIM_BITS-1:0], DIM_BITS'(WIDTH_LIMIT));
        end
        REG_IMAGE_HEIGHT: begin
          height_lim <= even_dim(cfg_data[DIM_BITS-1:0], DIM_BITS'(HEIGHT_LIMIT));
        end
        REG_PLANE_COUNT: begin
          plane_lim <= (cfg_data[PLANE_BITS-1:0] == '0) ? PLANE_BITS'(1)
                                                        : cfg_data[PLANE_BITS-1:0];
        end
        REG_AVERAGE_MODE: begin
          avg_mode <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input waits only on a full, stalled output register
  // ---------------------------------------------------------------------------
  logic accept;

  assign sample_stall = result_valid & result_stall;
  assign accept       = sample_valid & ~sample_stall;

  // ---------------------------------------------------------------------------
  // Position chain: column -> row -> plane
  // ---------------------------------------------------------------------------
  logic [CNT_BITS-1:0] col;
  logic [CNT_BITS-1:0] row;
  logic [CNT_BITS-1:0] plane;
  cnt_stat_t           col_stat;
  cnt_stat_t           row_stat;
  cnt_stat_t           plane_stat;

  pool_cnt_cell u_col_cell (
    .clk   (clk),
    .rst   (rst),
    .step  (accept),
    .limit (CNT_BITS'(width_lim)),
    .count (col),
    .stat  (col_stat)
  );

  pool_cnt_cell u_row_cell (
    .clk   (clk),
    .rst   (rst),
    .step  (col_stat.carry),
    .limit (CNT_BITS'(height_lim)),
    .count (row),
    .stat  (row_stat)
  );

  pool_cnt_cell u_plane_cell (
    .clk   (clk),
    .rst   (rst),
    .step  (row_stat.carry),
    .limit (CNT_BITS'(plane_lim)),
    .count (plane),
    .stat  (plane_stat)
  );

  // ---------------------------------------------------------------------------
  // Sample path
  // ---------------------------------------------------------------------------
  logic                          left_phase;   // even column
  logic                          emit;         // lower-right sample of a window
  logic [ADDR_BITS-1:0]          slot;
  logic signed [SAMPLE_BITS-1:0] pending;      // left sample of current pair
  logic [PAIR_BITS-1:0]          pair_sum;
  logic [PAIR_BITS-1:0]          upper_sum;
  logic                          store_wr;
  logic                          store_rd;
  logic [OUT_BITS-1:0]           win_sum;
  logic [OUT_BITS-1:0]           win_value;
  logic                          plane_done;

  assign left_phase = ~col[0];
  assign slot       = col[ADDR_BITS:1];
  assign store_rd   = accept & left_phase;
  assign store_wr   = accept & ~left_phase & ~row[0];
  assign emit       = accept & ~left_phase & row[0];

  assign pair_sum = {pending[SAMPLE_BITS-1], pending} + {sample[SAMPLE_BITS-1], sample};
  assign win_sum  = {upper_sum[PAIR_BITS-1], upper_sum}
                  + {{2{pending[SAMPLE_BITS-1]}}, pending}
                  + {{2{sample[SAMPLE_BITS-1]}}, sample};
  // arithmetic shift by two is floor(sum / 4)
  assign win_value  = avg_mode ? {{2{win_sum[OUT_BITS-1]}}, win_sum[OUT_BITS-1:2]} : win_sum;
  assign plane_done = col_stat.at_end & row_stat.at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (accept && left_phase) begin
      pending <= sample;
    end
  end

  pool_line_store u_line_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (slot),
    .wr_data (pair_sum),
    .rd_en   (store_rd),
    .rd_addr (slot),
    .rd_data (upper_sum)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pooled_value  <= win_value;
      last_of_plane <= plane_done;
      last_of_job   <= plane_done & plane_stat.at_end;
    end
  end

`ifndef NO_ASSERTIONS
  a_job_implies_plane: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!last_of_job || last_of_plane))
    else $error("job end flagged without plane end");

  a_plane_end_resets_pos: assert property (@(posedge clk) disable iff (rst)
    (accept && plane_done) |=> (col == '0 && row == '0))
    else $error("position not cleared after plane end");

  a_emit_loads_output: assert property (@(posedge clk) disable iff (rst)
    emit |=> result_valid)
    else $error("window result lost");

  a_store_one_port: assert property (@(posedge clk) disable iff (rst)
    !(store_wr && store_rd))
    else $error("line store read and write in one cycle");
`endif

endmodule
